[src/dsqu_pkg.sv]
// ----------------------------------------------------------------------------
// dsqu_pkg: shared definitions for the disjoint-set quick-union block
// Element index and count types, operation codes and table capacity.
// ----------------------------------------------------------------------------
package dsqu_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = 10;
  localparam int COUNT_W      = 11;
  localparam int KIND_W       = 2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [KIND_W-1:0]  kind_t;

  localparam kind_t KIND_FIND  = 2'd0;
  localparam kind_t KIND_UNION = 2'd1;
  localparam kind_t KIND_QUERY = 2'd2;

  localparam count_t COUNT_RESET = 11'd1024;

endpackage

[src/dsqu_in_if.sv]
// ----------------------------------------------------------------------------
// dsqu_in_if: request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface dsqu_in_if;
  import dsqu_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  idx_t  elem_a;
  idx_t  elem_b;

  modport source (output valid, output kind, output elem_a, output elem_b, input ready);
  modport sink   (input valid, input kind, input elem_a, input elem_b, output ready);

endinterface

[src/dsqu_out_if.sv]
// ----------------------------------------------------------------------------
// dsqu_out_if: result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface dsqu_out_if;
  import dsqu_pkg::*;

  logic valid;
  logic ready;
  logic status;
  idx_t root;
  logic same_set;

  modport source (output valid, output status, output root, output same_set, input ready);
  modport sink   (input valid, input status, input root, input same_set, output ready);

endinterface

[src/dsqu_ram.sv]
// ----------------------------------------------------------------------------
// dsqu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dsqu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[src/disjoint_set_quick_union.sv]
// ----------------------------------------------------------------------------
// disjoint_set_quick_union: disjoint-set forest, quick-union form
// Parent table in RAM, walked one link at a time by a small sequencer.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on in_chan (kind, elem_a, elem_b) and each one gives
// exactly one result item on out_chan (status, root, same_set). A find returns
// the root of elem_a; a union links the root of elem_a under the root of
// elem_b; a connected query reports whether both share a root. An index at or
// above the element count gives status 1 and leaves the table alone. The user is
// to write the element count through cfg_wr_en / cfg_wr_data while idle; not enforced.
//
// Timing. One request is worked at a time. Each element visited on a walk
// takes a RAM read state, then a compare on the registered read data. A find
// walks over the one read port from elem_a up to its root; a union or query
// then walks from elem_b up to its root as well. A rejected request skips the
// walks and goes straight to the result. The sequencer returns to idle after
// each item, so a new request is taken only once the last result is loaded.
//
// Reset. After rst_n the sequencer sweeps the parent table, writing each entry
// with its own index, one entry a cycle; in_chan.ready stays low throughout the
// sweep. Configuration writes are taken during the sweep.
//
// Stalls. The result sits in an output register; a new request is accepted
// while it waits, and that request's result is held back until the old one
// has been taken.
// ----------------------------------------------------------------------------
module disjoint_set_quick_union (
  input  logic                  clk,
  input  logic                  rst_n,
  dsqu_in_if.sink               in_chan,
  dsqu_out_if.source            out_chan,
  input  logic                  cfg_wr_en,
  input  dsqu_pkg::count_t      cfg_wr_data
);
  import dsqu_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD_A  = 3'd2;
  localparam logic [2:0] ST_CMP_A = 3'd3;
  localparam logic [2:0] ST_RD_B  = 3'd4;
  localparam logic [2:0] ST_CMP_B = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  idx_t       clr_cnt_r, clr_cnt_nxt;
  count_t     count_r, count_nxt;

  // Request held for the duration of the walk.
  kind_t      kind_r, kind_nxt;
  idx_t       elem_b_r, elem_b_nxt;
  logic       err_r, err_nxt;
  idx_t       cur_r, cur_nxt;
  idx_t       root_a_r, root_a_nxt;
  idx_t       root_b_r, root_b_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic       out_status_r, out_status_nxt;
  idx_t       out_root_r, out_root_nxt;
  logic       out_same_r, out_same_nxt;

  // Parent table port signals.
  logic       ram_we;
  idx_t       ram_waddr;
  idx_t       ram_wdata;
  idx_t       ram_rdata;

  count_t     live_count;
  logic       a_ok, b_ok;
  logic       at_root;
  logic       in_acc;
  logic       out_free;

  dsqu_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_parent (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (cur_r),
    .rd_data (ram_rdata)
  );

  // The count in force never exceeds the table capacity.
  assign live_count = (count_r > count_t'(MAX_ELEMENTS)) ? count_t'(MAX_ELEMENTS) : count_r;
  assign a_ok       = count_t'(in_chan.elem_a) < live_count;
  assign b_ok       = count_t'(in_chan.elem_b) < live_count;

  // The one compare shared by both walks: a root is its own parent.
  assign at_root = (ram_rdata == cur_r);

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // Table writes: the reset sweep, or the single link made by a union once
  // both roots are known and differ.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = clr_cnt_r;
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_r == ST_CMP_B && at_root && kind_r == KIND_UNION
                 && root_a_r != cur_r) begin
      ram_we    = 1'b1;
      ram_waddr = root_a_r;
      ram_wdata = cur_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    count_nxt      = count_r;
    kind_nxt       = kind_r;
    elem_b_nxt     = elem_b_r;
    err_nxt        = err_r;
    cur_nxt        = cur_r;
    root_a_nxt     = root_a_r;
    root_b_nxt     = root_b_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_root_nxt   = out_root_r;
    out_same_nxt   = out_same_r;

    if (cfg_wr_en) begin
      count_nxt = cfg_wr_data;
    end

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + idx_t'(1);
        if (clr_cnt_r == idx_t'(MAX_ELEMENTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt   = in_chan.kind;
          elem_b_nxt = in_chan.elem_b;
          cur_nxt    = in_chan.elem_a;
          root_a_nxt = in_chan.elem_a;
          root_b_nxt = in_chan.elem_b;
          case (in_chan.kind)
            KIND_FIND:  err_nxt = !a_ok;
            KIND_UNION: err_nxt = !(a_ok && b_ok);
            KIND_QUERY: err_nxt = !(a_ok && b_ok);
            default:    err_nxt = 1'b1;
          endcase
          state_nxt = err_nxt ? ST_DONE : ST_RD_A;
        end
      end
      ST_RD_A: begin
        state_nxt = ST_CMP_A;
      end
      ST_CMP_A: begin
        if (at_root) begin
          root_a_nxt = cur_r;
          if (kind_r == KIND_FIND) begin
            state_nxt = ST_DONE;
          end else begin
            cur_nxt   = elem_b_r;
            state_nxt = ST_RD_B;
          end
        end else begin
          cur_nxt   = ram_rdata;
          state_nxt = ST_RD_A;
        end
      end
      ST_RD_B: begin
        state_nxt = ST_CMP_B;
      end
      ST_CMP_B: begin
        if (at_root) begin
          root_b_nxt = cur_r;
          state_nxt  = ST_DONE;
        end else begin
          cur_nxt   = ram_rdata;
          state_nxt = ST_RD_B;
        end
      end
      ST_DONE: begin
        // Wait for the output register to free up before loading the result.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = err_r;
          out_root_nxt   = (!err_r && kind_r == KIND_FIND) ? root_a_r : idx_t'(0);
          out_same_nxt   = !err_r && kind_r == KIND_QUERY && root_a_r == root_b_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      count_r     <= COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    elem_b_r     <= elem_b_nxt;
    err_r        <= err_nxt;
    cur_r        <= cur_nxt;
    root_a_r     <= root_a_nxt;
    root_b_r     <= root_b_nxt;
    out_status_r <= out_status_nxt;
    out_root_r   <= out_root_nxt;
    out_same_r   <= out_same_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.root     = out_root_r;
  assign out_chan.same_set = out_same_r;

  // A union link never points a root at itself.
  a_no_self_link: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == ST_CMP_B) |-> (ram_wdata != ram_waddr))
    else $error("union wrote a self link");

  // The table is written only by the reset sweep or at the end of a union walk.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || (state_r == ST_CMP_B && kind_r == KIND_UNION)))
    else $error("parent table written outside sweep or union");

  // An error result carries no root and no same-set flag.
  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status) |-> (out_chan.root == '0 && !out_chan.same_set))
    else $error("error result with nonzero fields");

  // Acceptance of an item clears in_chan.ready, so no second item is taken right behind it.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_chan.ready)
    else $error("request accepted while another is in flight");

endmodule
